@@ hdl/jlo_pkg.sv @@
package jlo_pkg;

   localparam int DEFAULT_MAX_ELEMENTS = 1024;

   localparam int IDX_W     = 10;
   localparam int VAL_W     = 24;
   localparam int CNT_W     = 13;
   localparam int SUM_W     = 36;
   localparam int SQ_W      = 58;
   localparam int XX_W      = 47;
   localparam int DIV_W     = 58;
   localparam int DVS_W     = 14;
   localparam int ROOT_W    = DIV_W / 2;
   localparam int IDX_EXT_W = 17;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 112;

   localparam logic [CNT_W-1:0] MAX_SAMPLES  = 13'd4096;
   localparam logic [CNT_W-1:0] MIN_SAMPLES  = 13'd3;
   localparam logic [CNT_W-1:0] SAMPLE_RESET = 13'd3;

   localparam logic [1:0] REQ_CLEAR    = 2'd0;
   localparam logic [1:0] REQ_ACCUM    = 2'd1;
   localparam logic [1:0] REQ_RESAMPLE = 2'd2;

   localparam logic [VAL_W-1:0] MEAN_MAX = 24'h7fffff;
   localparam logic [VAL_W-1:0] MEAN_MIN = 24'h800000;
   localparam logic [VAL_W-1:0] ERR_MAX  = 24'hffffff;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_WIPE,
      OP_CLEAR,
      OP_SQUARE,
      OP_ACCUM,
      OP_MEAN_DIV,
      OP_MEAN_SET,
      OP_A_DIV,
      OP_A_SET,
      OP_NEG,
      OP_R_DIV,
      OP_SQRT,
      OP_ERR_SET,
      OP_OUT
   } op_type;

   typedef struct packed {
      logic   capture;
      op_type op;
      logic   part;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       in_range;
      logic       wipe_last;
      logic       div_busy;
      logic       sqrt_busy;
      logic       diff_neg;
   } status_type;

   typedef struct packed {
      logic [SUM_W-1:0] real_sum;
      logic [SQ_W-1:0]  real_sq;
      logic [SUM_W-1:0] imag_sum;
      logic [SQ_W-1:0]  imag_sq;
   } row_type;

endpackage

@@ hdl/jackknife_leave_one_out_stats_core.sv @@
// jackknife leave-one-out statistics, per element position
// req channel: req_tuser = request kind (0 clear, 1 accumulate, 2 resample),
//   req_tdata holds element index, real part, imag part (signed Q8.16)
// rsp channel: one transfer per in-range resample request, carrying index, leave-one-out
//   means and jackknife errors; rsp_tuser flags a clamped negative radicand
// csr_wen/csr_wdata write the sample count N, taken at any edge with csr_wen high
// one item is worked at a time
// resample works the real part, then the imaginary part:
//   each part runs three divides on a shared one-bit-per-cycle divider (58
//   steps each) and a square root that resolves two radicand bits per cycle
//   (29 steps); a clamped part skips both the last divide and the root
// after reset the sum memory is zeroed one row per cycle, all MAX_ELEMENTS rows,
//   with req_tready low
// the result sits in an output register; a new request is accepted while it
//   waits, and a finished result waits there until rsp_tready takes the old one
module jackknife_leave_one_out_stats_core
   import jlo_pkg::*;
#(
   parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // element_index, real_value, imag_value, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_index, real_mean, real_error, imag_mean, imag_error, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // clamped
   output logic [1:0]            rsp_tuser,
   input  logic                  csr_wen,
   input  logic [CNT_W-1:0]      csr_wdata
);

   cmd_type    cmd;
   status_type status;

   jlo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   jlo_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

@@ hdl/jlo_div.sv @@
module jlo_div
   import jlo_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [DIV_W-1:0] quotient
);

   localparam int CW = $clog2(DIV_W + 1);
   localparam logic [CW-1:0] STEPS = CW'(DIV_W);

   logic             busy_ff, busy_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEPS;
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[DIV_W-2:0], ge};
         rem_in  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = dvd_ff;

endmodule

@@ hdl/jlo_sqrt.sv @@
module jlo_sqrt
   import jlo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  radicand,
   output logic              busy,
   output logic [ROOT_W-1:0] root
);

   localparam int CW = $clog2(ROOT_W + 1);
   localparam logic [CW-1:0] STEPS = CW'(ROOT_W);

   logic              busy_ff, busy_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DIV_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W+2:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+2:0] cur;
   logic [ROOT_W+2:0] trial;
   logic              ge;

   always_comb begin
      cur     = {rem_ff[ROOT_W:0], rad_ff[DIV_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      ge      = cur >= trial;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEPS;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[DIV_W-3:0], 2'b00};
         rem_in  = ge ? (cur - trial) : cur;
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

@@ hdl/jlo_datapath.sv @@
module jlo_datapath
   import jlo_pkg::*;
#(
   parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [1:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_wen,
   input  logic [CNT_W-1:0]      csr_wdata,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser
);

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam logic [IDX_EXT_W-1:0] LAST_ROW = IDX_EXT_W'(MAX_ELEMENTS - 1);
   localparam logic [IDX_EXT_W-1:0] DEPTH    = IDX_EXT_W'(MAX_ELEMENTS);

   row_type mem [MAX_ELEMENTS];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [AW-1:0]     wipe_ff, wipe_in;

   logic [1:0]        kind_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [VAL_W-1:0]  xr_ff, xi_ff;
   row_type           rd_ff;
   logic [XX_W-1:0]   xxr_ff, xxi_ff;
   logic [VAL_W-1:0]  mr_ff, mi_ff;
   logic              sign_ff;
   logic [SQ_W:0]     a_ff;
   logic [XX_W-1:0]   mm_ff;
   logic [VAL_W-1:0]  er_ff, ei_ff;
   logic [1:0]        clamp_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [1:0]        rsp_user_ff;

   logic [IDX_W-1:0]     in_idx;
   logic [IDX_EXT_W-1:0] in_idx_ext, idx_ext;
   logic [AW-1:0]        rd_addr, idx_addr, wr_addr;
   logic                 wr_en;
   row_type              wr_data;

   logic [CNT_W-1:0]  n_eff, d1, d2;
   logic [SUM_W-1:0]  sum_sel;
   logic [SQ_W-1:0]   sq_sel;
   logic [VAL_W-1:0]  x_sel, m_sel;
   logic [XX_W-1:0]   xx_sel;
   logic [SUM_W:0]    num, mag;
   logic [SQ_W:0]     a_t, a_abs;
   logic [SQ_W+1:0]   diff;
   logic [2*VAL_W-1:0] prod_r, prod_i, prod_m;
   logic [VAL_W-1:0]  m_new, e_new;

   logic             div_start, div_busy;
   logic [DIV_W-1:0] div_dvd, quot;
   logic [DVS_W-1:0] div_dvs;
   logic             sqrt_start, sqrt_busy;
   logic [ROOT_W-1:0] root;

   assign in_idx     = req_tdata[IDX_W-1:0];
   assign in_idx_ext = {{(IDX_EXT_W-IDX_W){1'b0}}, in_idx};
   assign idx_ext    = {{(IDX_EXT_W-IDX_W){1'b0}}, idx_ff};
   assign rd_addr    = in_idx_ext[AW-1:0];
   assign idx_addr   = idx_ext[AW-1:0];

   always_comb begin
      if (count_ff < MIN_SAMPLES) begin
         n_eff = MIN_SAMPLES;
      end else if (count_ff > MAX_SAMPLES) begin
         n_eff = MAX_SAMPLES;
      end else begin
         n_eff = count_ff;
      end
      d1 = n_eff - CNT_W'(1);
      d2 = n_eff - CNT_W'(2);
   end

   always_comb begin
      sum_sel = cmd.part ? rd_ff.imag_sum : rd_ff.real_sum;
      sq_sel  = cmd.part ? rd_ff.imag_sq : rd_ff.real_sq;
      x_sel   = cmd.part ? xi_ff : xr_ff;
      xx_sel  = cmd.part ? xxi_ff : xxr_ff;
      m_sel   = cmd.part ? mi_ff : mr_ff;
      num = {sum_sel[SUM_W-1], sum_sel}
          - {{(SUM_W+1-VAL_W){x_sel[VAL_W-1]}}, x_sel};
      mag = num[SUM_W] ? (SUM_W+1)'(0) - num : num;
      a_t = {1'b0, sq_sel} - {{(SQ_W+1-XX_W){1'b0}}, xx_sel};
      a_abs = a_t[SQ_W] ? (SQ_W+1)'(0) - a_t : a_t;
      diff = {a_ff[SQ_W], a_ff} - {{(SQ_W+2-XX_W){1'b0}}, mm_ff};
      prod_r = (2*VAL_W)'($signed(xr_ff) * $signed(xr_ff));
      prod_i = (2*VAL_W)'($signed(xi_ff) * $signed(xi_ff));
      prod_m = (2*VAL_W)'($signed(m_sel) * $signed(m_sel));
      if (sign_ff) begin
         m_new = (quot > DIV_W'(MEAN_MIN)) ? MEAN_MIN : VAL_W'(0) - quot[VAL_W-1:0];
      end else begin
         m_new = (quot > DIV_W'(MEAN_MAX)) ? MEAN_MAX : quot[VAL_W-1:0];
      end
      e_new = (root > ROOT_W'(ERR_MAX)) ? ERR_MAX : root[VAL_W-1:0];
   end

   always_comb begin
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      case (cmd.op)
         OP_MEAN_DIV: begin
            div_start = 1'b1;
            div_dvd   = DIV_W'({mag, 1'b0}) + DIV_W'(d1);
            div_dvs   = {d1, 1'b0};
         end
         OP_A_DIV: begin
            div_start = 1'b1;
            div_dvd   = a_abs[DIV_W-1:0];
            div_dvs   = {1'b0, d1};
         end
         OP_R_DIV: begin
            div_start = 1'b1;
            div_dvd   = diff[DIV_W-1:0];
            div_dvs   = {1'b0, d2};
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
      sqrt_start = cmd.op == OP_SQRT;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_addr;
      wr_data = '0;
      case (cmd.op)
         OP_WIPE: begin
            wr_en   = 1'b1;
            wr_addr = wipe_ff;
         end
         OP_CLEAR: begin
            wr_en = 1'b1;
         end
         OP_ACCUM: begin
            wr_en = 1'b1;
            wr_data.real_sum = rd_ff.real_sum
                             + {{(SUM_W-VAL_W){xr_ff[VAL_W-1]}}, xr_ff};
            wr_data.imag_sum = rd_ff.imag_sum
                             + {{(SUM_W-VAL_W){xi_ff[VAL_W-1]}}, xi_ff};
            wr_data.real_sq  = rd_ff.real_sq + {{(SQ_W-XX_W){1'b0}}, xxr_ff};
            wr_data.imag_sq  = rd_ff.imag_sq + {{(SQ_W-XX_W){1'b0}}, xxi_ff};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.capture) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in = csr_wen ? csr_wdata : count_ff;
      wipe_in  = (cmd.op == OP_WIPE) ? wipe_ff + 1'b1 : wipe_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= SAMPLE_RESET;
         wipe_ff  <= '0;
      end else begin
         count_ff <= count_in;
         wipe_ff  <= wipe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_tuser;
         idx_ff  <= in_idx;
         xr_ff   <= req_tdata[IDX_W +: VAL_W];
         xi_ff   <= req_tdata[IDX_W+VAL_W +: VAL_W];
      end
      case (cmd.op)
         OP_SQUARE: begin
            xxr_ff <= prod_r[XX_W-1:0];
            xxi_ff <= prod_i[XX_W-1:0];
         end
         OP_MEAN_DIV: begin
            sign_ff <= num[SUM_W];
         end
         OP_MEAN_SET: begin
            if (cmd.part) begin
               mi_ff <= m_new;
            end else begin
               mr_ff <= m_new;
            end
         end
         OP_A_DIV: begin
            sign_ff <= a_t[SQ_W];
         end
         OP_A_SET: begin
            a_ff  <= sign_ff ? (SQ_W+1)'(0) - {1'b0, quot} : {1'b0, quot};
            mm_ff <= prod_m[XX_W-1:0];
         end
         OP_NEG: begin
            clamp_ff[cmd.part] <= 1'b1;
            if (cmd.part) begin
               ei_ff <= '0;
            end else begin
               er_ff <= '0;
            end
         end
         OP_ERR_SET: begin
            clamp_ff[cmd.part] <= 1'b0;
            if (cmd.part) begin
               ei_ff <= e_new;
            end else begin
               er_ff <= e_new;
            end
         end
         OP_OUT: begin
            rsp_data_ff <= {{(RSP_DATA_W-IDX_W-4*VAL_W){1'b0}},
                            ei_ff, mi_ff, er_ff, mr_ff, idx_ff};
            rsp_user_ff <= clamp_ff;
         end
         default: begin
            rsp_user_ff <= rsp_user_ff;
         end
      endcase
   end

   jlo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .quotient (quot)
   );

   jlo_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (quot),
      .busy     (sqrt_busy),
      .root     (root)
   );

   assign status.kind      = kind_ff;
   assign status.in_range  = idx_ext < DEPTH;
   assign status.wipe_last = {{(IDX_EXT_W-AW){1'b0}}, wipe_ff} == LAST_ROW;
   assign status.div_busy  = div_busy;
   assign status.sqrt_busy = sqrt_busy;
   assign status.diff_neg  = diff[SQ_W+1];

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

@@ hdl/jlo_ctrl.sv @@
module jlo_ctrl
   import jlo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [4:0] {
      S_WIPE,
      S_IDLE,
      S_DISPATCH,
      S_CLEAR,
      S_ACC_SQ,
      S_ACC_WR,
      S_RS_SQ,
      S_MEAN_GO,
      S_MEAN_WAIT,
      S_MEAN_SET,
      S_A_GO,
      S_A_WAIT,
      S_A_SET,
      S_D_CHECK,
      S_NEG,
      S_R_GO,
      S_R_WAIT,
      S_SQ_GO,
      S_SQ_WAIT,
      S_ERR,
      S_DONE
   } state_type;

   state_type state_ff;
   op_type    op_ff;
   logic      part_ff;
   logic      rsp_valid_ff;
   logic      xfer;

   assign req_tready = state_ff == S_IDLE;
   assign xfer       = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign cmd        = '{capture: xfer, op: op_ff, part: part_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WIPE;
         op_ff        <= OP_WIPE;
         part_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (op_ff == OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         op_ff <= OP_NONE;
         case (state_ff)
            S_WIPE: begin
               if (status.wipe_last) begin
                  state_ff <= S_IDLE;
               end else begin
                  op_ff <= OP_WIPE;
               end
            end
            S_IDLE: begin
               if (xfer) begin
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               part_ff <= 1'b0;
               if (!status.in_range) begin
                  state_ff <= S_IDLE;
               end else begin
                  case (status.kind)
                     REQ_CLEAR: begin
                        state_ff <= S_CLEAR;
                        op_ff    <= OP_CLEAR;
                     end
                     REQ_ACCUM: begin
                        state_ff <= S_ACC_SQ;
                        op_ff    <= OP_SQUARE;
                     end
                     REQ_RESAMPLE: begin
                        state_ff <= S_RS_SQ;
                        op_ff    <= OP_SQUARE;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_CLEAR: begin
               state_ff <= S_IDLE;
            end
            S_ACC_SQ: begin
               state_ff <= S_ACC_WR;
               op_ff    <= OP_ACCUM;
            end
            S_ACC_WR: begin
               state_ff <= S_IDLE;
            end
            S_RS_SQ: begin
               state_ff <= S_MEAN_GO;
               op_ff    <= OP_MEAN_DIV;
            end
            S_MEAN_GO: begin
               state_ff <= S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
               if (!status.div_busy) begin
                  state_ff <= S_MEAN_SET;
                  op_ff    <= OP_MEAN_SET;
               end
            end
            S_MEAN_SET: begin
               state_ff <= S_A_GO;
               op_ff    <= OP_A_DIV;
            end
            S_A_GO: begin
               state_ff <= S_A_WAIT;
            end
            S_A_WAIT: begin
               if (!status.div_busy) begin
                  state_ff <= S_A_SET;
                  op_ff    <= OP_A_SET;
               end
            end
            S_A_SET: begin
               state_ff <= S_D_CHECK;
            end
            S_D_CHECK: begin
               if (status.diff_neg) begin
                  state_ff <= S_NEG;
                  op_ff    <= OP_NEG;
               end else begin
                  state_ff <= S_R_GO;
                  op_ff    <= OP_R_DIV;
               end
            end
            S_R_GO: begin
               state_ff <= S_R_WAIT;
            end
            S_R_WAIT: begin
               if (!status.div_busy) begin
                  state_ff <= S_SQ_GO;
                  op_ff    <= OP_SQRT;
               end
            end
            S_SQ_GO: begin
               state_ff <= S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
               if (!status.sqrt_busy) begin
                  state_ff <= S_ERR;
                  op_ff    <= OP_ERR_SET;
               end
            end
            S_NEG, S_ERR: begin
               if (part_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  part_ff  <= 1'b1;
                  state_ff <= S_MEAN_GO;
                  op_ff    <= OP_MEAN_DIV;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  state_ff <= S_IDLE;
                  op_ff    <= OP_OUT;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      op_ff == OP_OUT |-> !rsp_valid_ff)
      else $error("result register overwritten before transfer");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (op_ff == OP_MEAN_DIV || op_ff == OP_A_DIV || op_ff == OP_R_DIV)
      |-> !status.div_busy)
      else $error("divide issued while divider busy");

   a_sqrt_idle: assert property (@(posedge clock) disable iff (reset)
      op_ff == OP_SQRT |-> !status.sqrt_busy && !status.div_busy)
      else $error("square root issued while a unit is busy");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      op_ff == OP_OUT |=> rsp_valid_ff)
      else $error("result not presented after load");
`endif

endmodule
